// ----- hw/rtl/ris_pkg.sv -----
// Shared constants, register codes and types for the ranked index selector.
package ris_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 6;
    localparam int DIR_W        = 1;
    localparam int COUNT_W      = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_WANTED = 2'd1;

    localparam logic [COUNT_W-1:0] COUNT_WANTED_RST = 7'd64;

    // One compare slot presented to the scan unit.
    typedef struct packed {
        logic             clear;
        logic             valid;
        logic             largest;
        logic [POS_W-1:0] pos;
    } t_scan_ctl;

endpackage

// ----- hw/rtl/ris_key_ram.sv -----
// Key storage: one write port, one registered read port.
module ris_key_ram
    import ris_pkg::*;
#(
    parameter int DEPTH = MAX_KEYS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [KEY_W-1:0] o_rdata
);

    logic [KEY_W-1:0] r_mem [DEPTH];
    logic [KEY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ris_scan_unit.sv -----
// Shared compare unit: keeps the best untaken key seen during one scan.
module ris_scan_unit
    import ris_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_key,
    output logic [POS_W-1:0] o_best_pos
);

    logic             r_found;
    logic [KEY_W-1:0] r_best_val;
    logic [POS_W-1:0] r_best_pos;
    logic             better;

    // Strict compare keeps the lowest position on ties.
    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (i_ctl.largest) begin
            better = $signed(i_key) > $signed(r_best_val);
        end else begin
            better = $signed(i_key) < $signed(r_best_val);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.valid && better) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_ctl.clear && i_ctl.valid && better) begin
            r_best_val <= i_key;
            r_best_pos <= i_ctl.pos;
        end
    end

    assign o_best_pos = r_best_pos;

endmodule

// ----- hw/rtl/ranked_index_selector_core.sv -----
// Top level of the ranked index selector: key loading, scan sequencer and output register.
//
// Keys are loaded one request per cycle into a MAX_KEYS-entry key RAM; keys past
// MAX_KEYS in a set are dropped, but their last_key flag still closes the set.
// The request carrying last_key starts the ranking: for each of
// min(count_wanted, keys loaded) results the sequencer sweeps the RAM once,
// feeding one stored key per cycle through a single shared signed comparator,
// skipping positions already taken. Ties go to the lowest position. Each result
// takes the reads of the sweep, the return and compare of the last read, a drain
// step that sees the read pipe empty, and an emit step; the drain step is saved
// when the last position is already taken. While ranking runs the input stalls;
// a finished result waits in the output register while the next sweep proceeds,
// and the emit cycle stretches while that register is still held by a stalled
// receiver. New keys are taken as soon as the last result is registered.
// direction 0 ranks smallest first, 1 largest first. Write the configuration
// registers only while the block is idle.
module ranked_index_selector_core
    import ris_pkg::*;
#(
    parameter int MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    // key requests
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic signed [KEY_W-1:0] i_key_value,
    input  logic                   i_last_key,
    // ranked positions
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [POS_W-1:0]       o_ranked_position,
    output logic                   o_last_rank
);

    localparam int PW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_KEYS);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [DIR_W-1:0]    r_direction;
    logic [COUNT_W-1:0]  r_count_wanted;
    logic [CW-1:0]       r_loaded, n_loaded;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_emitted, n_emitted;
    logic [CW-1:0]       r_scan_idx, n_scan_idx;
    logic [MAX_KEYS-1:0] r_taken, n_taken;
    logic                r_rd_vld, n_rd_vld;
    logic [POS_W-1:0]    r_rd_pos, n_rd_pos;
    logic                r_out_vld, n_out_vld;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic                r_out_last, n_out_last;

    logic                in_fire;
    logic                out_free;
    logic                ram_we;
    logic [CW-1:0]       set_size;
    logic [COUNT_W-1:0]  set_size_ext;
    logic [KEY_W-1:0]    ram_rdata;
    logic [POS_W-1:0]    best_pos;
    logic                emit_last;
    t_scan_ctl           scan_ctl;

    assign o_in_stall = (r_state != ST_LOAD);
    assign in_fire    = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_vld || !i_out_stall;
    assign ram_we     = in_fire && (r_loaded < MAX_CNT);

    // Keys in the set once the closing request is stored.
    assign set_size     = ram_we ? CW'(r_loaded + 1'b1) : r_loaded;
    assign set_size_ext = COUNT_W'(set_size);
    assign emit_last    = (CW'(r_emitted + 1'b1) == r_count);

    // Configuration registers; other indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction    <= '0;
            r_count_wanted <= COUNT_WANTED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DIRECTION:    r_direction    <= i_cfg_data[DIR_W-1:0];
                REG_COUNT_WANTED: r_count_wanted <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_loaded   = r_loaded;
        n_count    = r_count;
        n_emitted  = r_emitted;
        n_scan_idx = r_scan_idx;
        n_taken    = r_taken;
        n_rd_vld   = 1'b0;
        n_rd_pos   = r_rd_pos;
        n_out_vld  = r_out_vld && i_out_stall;
        n_out_pos  = r_out_pos;
        n_out_last = r_out_last;

        unique case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    // clear taken marks on the first key of a set
                    if (r_loaded == '0) begin
                        n_taken = '0;
                    end
                    n_loaded = set_size;
                    if (i_last_key) begin
                        n_emitted  = '0;
                        n_scan_idx = '0;
                        if (r_count_wanted > set_size_ext) begin
                            n_count = set_size;
                        end else begin
                            n_count = CW'(r_count_wanted);
                        end
                        if (r_count_wanted == '0) begin
                            n_loaded = '0;
                        end else begin
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (r_scan_idx < r_loaded) begin
                    // issue one read per cycle, skip taken positions
                    n_rd_vld   = !r_taken[r_scan_idx[PW-1:0]];
                    n_rd_pos   = POS_W'(r_scan_idx);
                    n_scan_idx = CW'(r_scan_idx + 1'b1);
                end else if (!r_rd_vld) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_vld                = 1'b1;
                    n_out_pos                = best_pos;
                    n_out_last               = emit_last;
                    n_taken[best_pos[PW-1:0]] = 1'b1;
                    n_emitted                = CW'(r_emitted + 1'b1);
                    n_scan_idx               = '0;
                    if (emit_last) begin
                        n_loaded = '0;
                        n_state  = ST_LOAD;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_LOAD;
            r_loaded  <= '0;
            r_taken   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_count   <= '0;
            r_emitted <= '0;
            r_scan_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_taken    <= n_taken;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
            r_count    <= n_count;
            r_emitted  <= n_emitted;
            r_scan_idx <= n_scan_idx;
        end
    end

    // Payload registers, no reset.
    always_ff @(posedge i_clk) begin
        r_rd_pos   <= n_rd_pos;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

    ris_key_ram #(
        .DEPTH (MAX_KEYS),
        .AW    (PW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_loaded[PW-1:0]),
        .i_wdata (i_key_value),
        .i_raddr (r_scan_idx[PW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Hold the best-so-far only while sweeping.
    always_comb begin
        scan_ctl.clear   = (r_state != ST_SCAN);
        scan_ctl.valid   = r_rd_vld;
        scan_ctl.largest = r_direction[0];
        scan_ctl.pos     = r_rd_pos;
    end

    ris_scan_unit u_scan_unit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_key      (ram_rdata),
        .o_best_pos (best_pos)
    );

    assign o_out_valid       = r_out_vld;
    assign o_ranked_position = r_out_pos;
    assign o_last_rank       = r_out_last;

endmodule
